// ===== sv/scfp_pkg.sv =====
// scfp_pkg: shared types and constants of the sum checked frame parser
// no dependencies; imported by the top level, scfp_rx, scfp_tx and the dv files
package scfp_pkg;

  localparam int LEN_W = 6;

  localparam logic [7:0] HEADER_BYTE   = 8'h3E;
  localparam logic [7:0] CMD_LIMIT_RST = 8'd8;

  // descriptor of a frame whose checksum came out right
  typedef struct packed {
    logic             start;
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
  } frame_t;

endpackage

// ===== sv/sum_checked_frame_parser.sv =====
// sum_checked_frame_parser: top level, parser + payload store + result drain
// the checksum transfer of a good frame sets busy, then out_valid is raised
// throughput: one received byte per cycle while in_ready is high;
//   after a good frame, input is held off while results drain from the store
// reset: synchronous active low rst_n; phase, sums and command limit (8) reset
// depends on scfp_pkg, scfp_rx, scfp_buf, scfp_tx
module sum_checked_frame_parser #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // received byte channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  // command limit register
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_command_code,
  output logic [scfp_pkg::LEN_W-1:0]    out_payload_length,
  output logic                          out_has_payload,
  output logic [7:0]                    out_payload_byte,
  output logic [scfp_pkg::LEN_W-1:0]    out_byte_position,
  output logic                          out_last
);

  import scfp_pkg::*;

  // payload store holds at most buffer size minus header, command, length, checksum
  localparam int DEPTH = BUFFER_BYTES - 4;
  localparam int AW    = $clog2(DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          busy;
  frame_t        frame;

  // the store has one write and one read port, so reception stops while a frame drains
  assign in_ready = !busy;

  scfp_rx #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .frame      (frame)
  );

  // payload bytes of the frame in flight
  scfp_buf #(
    .DEPTH(DEPTH)
  ) u_buf (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data)
  );

  // one result per payload byte, or one empty result for a zero length frame
  scfp_tx #(
    .DEPTH(DEPTH)
  ) u_tx (
    .clk               (clk),
    .rst_n             (rst_n),
    .frame             (frame),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command_code  (out_command_code),
    .out_payload_length(out_payload_length),
    .out_has_payload   (out_has_payload),
    .out_payload_byte  (out_payload_byte),
    .out_byte_position (out_byte_position),
    .out_last          (out_last)
  );

endmodule

// ===== sv/scfp_buf.sv =====
// scfp_buf: payload store, one write port and one read port
// read data is registered; no dependencies
module scfp_buf #(
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== sv/scfp_rx.sv =====
// scfp_rx: header hunt, field parse, running sum and payload writes
// depends on scfp_pkg; drives scfp_buf and hands frames to scfp_tx
module scfp_rx #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  input  logic                                       in_ready,
  input  logic [7:0]                                 in_rx_byte,
  input  logic                                       cfg_wr_en,
  input  logic [7:0]                                 cfg_wr_data,
  output logic                                       wr_en,
  output logic [$clog2(BUFFER_BYTES-4)-1:0]          wr_addr,
  output logic [7:0]                                 wr_data,
  output scfp_pkg::frame_t                           frame
);

  import scfp_pkg::*;

  localparam int         AW        = $clog2(BUFFER_BYTES - 4);
  localparam logic [7:0] LEN_LIMIT = 8'(BUFFER_BYTES - 3);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       limit_r;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] rem_dec;
  logic [7:0]       total;
  logic             accept;

  assign accept  = in_valid && in_ready;
  assign pos     = len_r - rem_r;
  assign rem_dec = rem_r - LEN_W'(1);
  assign total   = sum_r + in_rx_byte;

  assign wr_addr = pos[AW-1:0];
  assign wr_data = in_rx_byte;

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    sum_nxt     = sum_r;
    wr_en       = 1'b0;
    frame.start = 1'b0;
    frame.cmd   = cmd_r;
    frame.len   = len_r;
    if (accept) begin
      unique case (phase_r)
        PH_CMD: begin
          if (in_rx_byte < limit_r) begin
            cmd_nxt   = in_rx_byte;
            sum_nxt   = total;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (in_rx_byte == 8'd0) begin
            len_nxt   = '0;
            rem_nxt   = '0;
            sum_nxt   = total;
            phase_nxt = PH_SUM;
          end else if (in_rx_byte < LEN_LIMIT) begin
            len_nxt   = in_rx_byte[LEN_W-1:0];
            rem_nxt   = in_rx_byte[LEN_W-1:0];
            sum_nxt   = total;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          wr_en   = 1'b1;
          sum_nxt = total;
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          // good frame when everything from header to checksum sums to zero
          frame.start = (total == 8'd0);
          phase_nxt   = PH_HUNT;
        end
        default: begin
          if (in_rx_byte == HEADER_BYTE) begin
            sum_nxt   = in_rx_byte;
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      limit_r <= CMD_LIMIT_RST;
      cmd_r   <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      sum_r   <= sum_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== sv/scfp_tx.sv =====
// scfp_tx: drains good frames from the store, one result a cycle if out_ready
// depends on scfp_pkg; reads scfp_buf, frames come from scfp_rx
module scfp_tx #(
  parameter int DEPTH = 60
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scfp_pkg::frame_t                    frame,
  output logic [$clog2(DEPTH)-1:0]            rd_addr,
  input  logic [7:0]                          rd_data,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_command_code,
  output logic [scfp_pkg::LEN_W-1:0]          out_payload_length,
  output logic                                out_has_payload,
  output logic [7:0]                          out_payload_byte,
  output logic [scfp_pkg::LEN_W-1:0]          out_byte_position,
  output logic                                out_last
);

  import scfp_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic             busy_r;
  logic             valid_r;
  logic [AW-1:0]    idx_r;
  logic [7:0]       cmd_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] idx_ext;
  logic             has_pl;
  logic             last_w;
  logic             xfer;

  assign idx_ext = LEN_W'(idx_r);
  assign has_pl  = (len_r != '0);
  assign last_w  = !has_pl || (idx_ext == len_r - LEN_W'(1));
  assign xfer    = valid_r && out_ready;

  // read ahead to the next entry on a transfer so the data is ready next cycle
  assign rd_addr = (xfer && !last_w) ? idx_r + AW'(1) : idx_r;

  assign busy               = busy_r;
  assign out_valid          = valid_r;
  assign out_command_code   = cmd_r;
  assign out_payload_length = len_r;
  assign out_has_payload    = has_pl;
  assign out_payload_byte   = has_pl ? rd_data : 8'd0;
  assign out_byte_position  = idx_ext;
  assign out_last           = last_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (frame.start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (busy_r && !valid_r) begin
      valid_r <= 1'b1;
    end else if (xfer) begin
      if (last_w) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.start) begin
      cmd_r <= frame.cmd;
      len_r <= frame.len;
    end
  end

endmodule

// ===== sv/scfp_checker.sv =====
// scfp_checker: port level checks of the frame parser over time
// no package dependency; bound to sum_checked_frame_parser below
module scfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_payload_length,
  input logic       out_has_payload,
  input logic [7:0] out_payload_byte,
  input logic [5:0] out_byte_position,
  input logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_byte_position) && $stable(out_last))
    else $error("result changed while stalled");

  // no byte is received while a frame drains
  a_no_rx_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during drain");

  // an empty frame gives a single final result
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_payload |-> out_last && out_payload_length == 6'd0
      && out_byte_position == 6'd0 && out_payload_byte == 8'd0)
    else $error("malformed empty result");

  // positions step by one within a frame
  a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid
      && out_byte_position == $past(out_byte_position) + 6'd1)
    else $error("payload position skipped");

  // the final transfer ends the frame
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after last");

endmodule

bind sum_checked_frame_parser scfp_checker u_scfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_payload_length(out_payload_length),
  .out_has_payload   (out_has_payload),
  .out_payload_byte  (out_payload_byte),
  .out_byte_position (out_byte_position),
  .out_last          (out_last)
);

// ===== dv/scfp_frame_checker.sv =====
// scfp_frame_checker: watches the byte, command limit and result ports of the frame
// parser, predicts the results of every good frame and compares them in order
// depends on scfp_pkg
module scfp_frame_checker #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_command_code,
  input  logic [scfp_pkg::LEN_W-1:0]    out_payload_length,
  input  logic                          out_has_payload,
  input  logic [7:0]                    out_payload_byte,
  input  logic [scfp_pkg::LEN_W-1:0]    out_byte_position,
  input  logic                          out_last,
  output int                            mismatch_count,
  output int                            pending_count
);
  import scfp_pkg::*;

  localparam int MAX_PAYLOAD = BUFFER_BYTES - 4;
  localparam int MAX_PRINTED = 40;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_SUM
  } parse_state_e;

  typedef struct packed {
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
    logic             has;
    logic [7:0]       data;
    logic [LEN_W-1:0] pos;
    logic             last;
  } frame_beat_t;

  parse_state_e     parse_state;
  logic [7:0]       cmd_limit;
  logic [7:0]       held_cmd;
  logic [7:0]       run_sum;
  logic [LEN_W-1:0] held_len;
  logic [LEN_W-1:0] bytes_left;
  logic [7:0]       payload_mem [MAX_PAYLOAD];
  frame_beat_t      expected_beats [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] result mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // one accepted byte through the parser; a good checksum queues the whole frame
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0]       total;
    logic [LEN_W-1:0] pos;
    frame_beat_t      beat;
    case (parse_state)
      ST_CMD: begin
        if (b < cmd_limit) begin
          held_cmd    = b;
          run_sum     = run_sum + b;
          parse_state = ST_LEN;
        end else begin
          parse_state = ST_HUNT;
        end
      end
      ST_LEN: begin
        if (b == 8'd0) begin
          held_len    = '0;
          bytes_left  = '0;
          parse_state = ST_SUM;
        end else if (b < BUFFER_BYTES - 3) begin
          held_len    = b[LEN_W-1:0];
          bytes_left  = b[LEN_W-1:0];
          run_sum     = run_sum + b;
          parse_state = ST_DATA;
        end else begin
          parse_state = ST_HUNT;
        end
      end
      ST_DATA: begin
        pos = held_len - bytes_left;
        if (pos < MAX_PAYLOAD) payload_mem[pos] = b;
        run_sum    = run_sum + b;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) parse_state = ST_SUM;
      end
      ST_SUM: begin
        total = run_sum + b;
        if (total == 8'd0) begin
          if (held_len == '0) begin
            beat = '{cmd: held_cmd, len: '0, has: 1'b0, data: 8'd0, pos: '0, last: 1'b1};
            expected_beats.push_back(beat);
          end else begin
            for (int k = 0; k < held_len && k < MAX_PAYLOAD; k++) begin
              beat.cmd  = held_cmd;
              beat.len  = held_len;
              beat.has  = 1'b1;
              beat.data = payload_mem[k];
              beat.pos  = LEN_W'(k);
              beat.last = (k + 1 == held_len);
              expected_beats.push_back(beat);
            end
          end
        end
        parse_state = ST_HUNT;
      end
      default: begin
        if (b == HEADER_BYTE) begin
          run_sum     = b;
          parse_state = ST_CMD;
        end else begin
          parse_state = ST_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch_ports
    frame_beat_t got_beat;
    frame_beat_t want_beat;
    if (!rst_n) begin
      cmd_limit   = CMD_LIMIT_RST;
      parse_state = ST_HUNT;
      held_cmd    = 8'd0;
      held_len    = '0;
      bytes_left  = '0;
      run_sum     = 8'd0;
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) cmd_limit = cfg_wr_data;
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        got_beat = '{cmd: out_command_code, len: out_payload_length, has: out_has_payload,
                     data: out_payload_byte, pos: out_byte_position, last: out_last};
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected result, command %0h byte %0h position %0d",
                                    got_beat.cmd, got_beat.data, got_beat.pos));
        end else begin
          want_beat = expected_beats.pop_front();
          if (got_beat.cmd !== want_beat.cmd)
            report_mismatch($sformatf("command_code %0h, expected %0h",
                                      got_beat.cmd, want_beat.cmd));
          if (got_beat.len !== want_beat.len)
            report_mismatch($sformatf("payload_length %0d, expected %0d",
                                      got_beat.len, want_beat.len));
          if (got_beat.has !== want_beat.has)
            report_mismatch($sformatf("has_payload %0b, expected %0b",
                                      got_beat.has, want_beat.has));
          if (got_beat.data !== want_beat.data)
            report_mismatch($sformatf("payload_byte %0h, expected %0h at position %0d",
                                      got_beat.data, want_beat.data, want_beat.pos));
          if (got_beat.pos !== want_beat.pos)
            report_mismatch($sformatf("byte_position %0d, expected %0d",
                                      got_beat.pos, want_beat.pos));
          if (got_beat.last !== want_beat.last)
            report_mismatch($sformatf("last %0b, expected %0b at position %0d",
                                      got_beat.last, want_beat.last, want_beat.pos));
        end
      end
    end
    pending_count <= expected_beats.size();
  end

endmodule

// ===== dv/sum_checked_frame_parser_test.sv =====
// sum_checked_frame_parser_test: stimulus and verdict for the frame parser,
// with the frame checker beside the block doing prediction and comparison
// depends on scfp_pkg, scfp_frame_checker and the sum_checked_frame_parser rtl
module sum_checked_frame_parser_test;
  import scfp_pkg::*;

  localparam int BUFFER_BYTES    = 64;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int HOLD_OFF_CYCLES = 400;
  // a byte that makes no result can still be in flight when the queue empties
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_CYCLES      = 20;
  localparam int N_DIRECTED      = 30;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_rx_byte;
  logic                cfg_wr_en;
  logic [7:0]          cfg_wr_data;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          out_command_code;
  logic [LEN_W-1:0]    out_payload_length;
  logic                out_has_payload;
  logic [7:0]          out_payload_byte;
  logic [LEN_W-1:0]    out_byte_position;
  logic                out_last;

  int                  mismatch_count;
  int                  pending_count;

  // knobs shared by the sender and receiver processes
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_request   = 1'b0;
  int                  bytes_in_phase = 0;
  logic [7:0]          limit_now      = CMD_LIMIT_RST;
  logic [7:0]          directed_bytes [0:N_DIRECTED-1];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sum_checked_frame_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command_code   (out_command_code),
    .out_payload_length (out_payload_length),
    .out_has_payload    (out_has_payload),
    .out_payload_byte   (out_payload_byte),
    .out_byte_position  (out_byte_position),
    .out_last           (out_last)
  );

  scfp_frame_checker #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) frame_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command_code   (out_command_code),
    .out_payload_length (out_payload_length),
    .out_has_payload    (out_has_payload),
    .out_payload_byte   (out_payload_byte),
    .out_byte_position  (out_byte_position),
    .out_last           (out_last),
    .mismatch_count     (mismatch_count),
    .pending_count      (pending_count)
  );

  // watchdog: a hung handshake or a result that never comes ends here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // result receiver: random stalls, plus one long hold-off on request
  // so the block fills up and pushes back on the byte channel
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one byte transfer; random idle cycles first, then valid held until ready
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_in_phase++;
  endtask

  // header, command, length, payload and checksum; fill below zero means random payload
  task automatic send_frame(input logic [7:0] cmd, input int len, input bit bad_sum,
                            input int fill);
    logic [7:0] run_sum;
    logic [7:0] b;
    run_sum = HEADER_BYTE + cmd + 8'(len);
    send_byte(HEADER_BYTE);
    send_byte(cmd);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      run_sum = run_sum + b;
      send_byte(b);
    end
    b = 8'd0 - run_sum;
    // any nonzero offset breaks the zero sum
    if (bad_sum) b = b + 8'($urandom_range(1, 255));
    send_byte(b);
  endtask

  // mostly well formed frames, the rest broken headers and line noise
  task automatic send_random_unit();
    int         pick;
    int         len_pick;
    int         len;
    logic [7:0] cmd;
    pick     = $urandom_range(99);
    len_pick = $urandom_range(99);
    if (limit_now != 8'd0 && pick < 70) cmd = 8'($urandom_range(int'(limit_now) - 1));
    else cmd = 8'($urandom_range(255));
    // small frames dominate, the full 60 byte payload shows up now and then
    if (len_pick < 65) len = $urandom_range(4);
    else if (len_pick < 90) len = $urandom_range(5, 16);
    else if (len_pick < 98) len = $urandom_range(17, 59);
    else len = BUFFER_BYTES - 4;
    if (pick < 80) begin
      send_frame(cmd, len, ($urandom_range(99) < 12), -1);
    end else if (pick < 88) begin
      // length past the buffer
      send_byte(HEADER_BYTE);
      send_byte(cmd);
      send_byte(8'($urandom_range(BUFFER_BYTES - 3, 255)));
    end else if (pick < 94) begin
      // header followed by anything
      send_byte(HEADER_BYTE);
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // sender pause until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_now    = value;
  endtask

  task automatic run_phase(input int n_bytes, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    bytes_in_phase = 0;
    while (bytes_in_phase < n_bytes) send_random_unit();
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_rx_byte  <= 8'd0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'd0;
    rst_n       <= 1'b0;

    directed_bytes = '{
      // empty frame, command 0
      8'h3E, 8'h00, 8'h00, 8'hC2,
      // one byte payload 0xff, highest command under the reset limit
      8'h3E, 8'h07, 8'h01, 8'hFF, 8'hBB,
      // command 0x3e rejected; it must not restart a frame that the tail would complete
      8'h3E, 8'h3E, 8'h00, 8'h00, 8'hC2,
      // length 0x3e rejected, same trap as above
      8'h3E, 8'h01, 8'h3E, 8'h01, 8'h00, 8'hC1,
      // bad checksum that equals the header, then the same trap
      8'h3E, 8'h00, 8'h00, 8'h3E, 8'h00, 8'h00, 8'hC2,
      // length one past the maximum
      8'h3E, 8'h01, 8'h3D
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset command limit, no idling
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // widest limit: only command 0xff is refused
    write_limit(8'hFF);
    run_phase(40, 0, 0);

    // limit zero: every frame dies at its command byte, sender mostly idle
    write_limit(8'h00);
    run_phase(30, 70, 0);

    // random limit, receiver stalling and one long hold-off while bytes keep coming
    write_limit(8'($urandom_range(2, 254)));
    hold_request = 1'b1;
    run_phase(50, 0, 70);

    // only command 0 passes, both sides idling
    write_limit(8'h01);
    run_phase(40, 36, 36);

    // back to the reset limit, opening with a full size payload
    write_limit(CMD_LIMIT_RST);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame(CMD_LIMIT_RST - 8'd1, BUFFER_BYTES - 4, 1'b0, -1);
    run_phase(20, 0, 0);

    // all stimulus transferred: wait out the results and the pipeline
    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/scfp_pkg.sv
sv/scfp_buf.sv
sv/scfp_rx.sv
sv/scfp_tx.sv
sv/sum_checked_frame_parser.sv
sv/scfp_checker.sv
dv/scfp_frame_checker.sv
dv/sum_checked_frame_parser_test.sv
